/* rtl/delta_queue_task_scheduler_defines.svh */
// Assertion macros used by the scheduler controller.
// No dependencies.
`ifndef DELTA_QUEUE_TASK_SCHEDULER_DEFINES_SVH
`define DELTA_QUEUE_TASK_SCHEDULER_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define DQ_ASSERT_IMP(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define DQ_ASSERT_NXT(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) else $error(msg);
`endif

/* rtl/dqts_pkg.sv */
// Types and constants for the delta-list task scheduler.
// No dependencies.
package dqts_pkg;
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_ADD  = 2'd1;
	localparam logic [1:0] OP_DEL  = 2'd2;
	localparam logic [2:0] ST_FIRED   = 3'd0;
	localparam logic [2:0] ST_ADDED   = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_REMOVED = 3'd3;
	localparam logic [2:0] ST_NOTFND  = 3'd4;
	localparam int FIRE_LIMIT = 16;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  task_id;
		logic [15:0] delay;
		logic [15:0] period;
	} in_t;

	typedef struct packed {
		logic [7:0] result_id;
		logic [2:0] status;
		logic       last;
	} out_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture input item
		logic tick_dec;   // decrement head delta
		logic fire_pop;   // remove head, latch it as a fire
		logic ins_start;  // start insert walk (from item or from fired task)
		logic ins_src;    // 0: item, 1: fired task
		logic ins_step;   // advance insert walk one entry
		logic ins_do;     // commit insert at current position
		logic del_start;
		logic del_step;
		logic del_do;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic full;
		logic head_zero;
		logic ins_here;   // walk stops at current position
		logic del_hit;    // current entry matches id
		logic del_end;    // walked past last entry
		logic fire_per;   // popped task is periodic
	} stat_t;
endpackage

/* rtl/dqts_if.sv */
// Valid/ready channel carrying one payload struct.
// Depends on nothing but its type parameter.
interface dqts_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/dqts_dp.sv */
// Datapath: entry table in registers, walk position, item latch.
// Depends on dqts_pkg.
module dqts_dp #(
	parameter int MAX_TASKS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dqts_pkg::in_t     item,
	input  dqts_pkg::cmd_t    cmd,
	output dqts_pkg::stat_t   stat,
	output logic [7:0]        cur_id
);
	localparam int IW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);

	logic [7:0]  ids_q   [MAX_TASKS];
	logic [15:0] dlt_q   [MAX_TASKS];
	logic [15:0] per_q   [MAX_TASKS];
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] pos_q;
	logic [15:0] d_q;
	logic [7:0]  id_q;
	logic [15:0] nper_q;
	logic [7:0]  fid_q;
	logic [15:0] fper_q;

	logic [IW-1:0] pi;
	logic          pos_in;

	assign pi     = pos_q[IW-1:0];
	assign pos_in = pos_q < cnt_q;

	assign stat.empty     = cnt_q == '0;
	assign stat.full      = cnt_q == CW'(MAX_TASKS);
	assign stat.head_zero = dlt_q[0] == '0;
	assign stat.ins_here  = !pos_in || (d_q < dlt_q[pi]);
	assign stat.del_hit   = pos_in && ids_q[pi] == id_q;
	assign stat.del_end   = !pos_in;
	assign stat.fire_per  = fper_q != '0;
	assign cur_id = cmd.fire_pop ? ids_q[0] : id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.fire_pop || cmd.del_do) begin
			cnt_q <= cnt_q - 1'b1;
		end else if (cmd.ins_do) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// walk registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q   <= item.task_id;
			d_q    <= item.delay;
			nper_q <= item.period;
		end
		if (cmd.fire_pop) begin
			fid_q  <= ids_q[0];
			fper_q <= per_q[0];
		end
		if (cmd.ins_start || cmd.del_start) begin
			pos_q <= '0;
			if (cmd.ins_src) begin
				id_q   <= fid_q;
				d_q    <= fper_q;
				nper_q <= fper_q;
			end
		end else if (cmd.ins_step) begin
			d_q   <= d_q - dlt_q[pi];
			pos_q <= pos_q + 1'b1;
		end else if (cmd.del_step) begin
			pos_q <= pos_q + 1'b1;
		end
	end

	// table updates: head decrement and shifts; each entry updated from its neighbors at once
	always_ff @(posedge clk) begin
		if (cmd.tick_dec && dlt_q[0] != '0) begin
			dlt_q[0] <= dlt_q[0] - 1'b1;
		end
		for (int i = 0; i < MAX_TASKS; i++) begin
			if (cmd.fire_pop || cmd.del_do) begin
				if (cmd.fire_pop || CW'(i) >= pos_q) begin
					if (i + 1 < MAX_TASKS && CW'(i + 1) < cnt_q) begin
						ids_q[i] <= ids_q[(i + 1) % MAX_TASKS];
						per_q[i] <= per_q[(i + 1) % MAX_TASKS];
						if ((cmd.fire_pop && i == 0) || (cmd.del_do && CW'(i) == pos_q)) begin
							if ({1'b0, dlt_q[(i + 1) % MAX_TASKS]} + {1'b0, dlt_q[i]}
								> 17'h0FFFF)
								dlt_q[i] <= 16'hFFFF;
							else
								dlt_q[i] <= dlt_q[(i + 1) % MAX_TASKS] + dlt_q[i];
						end else begin
							dlt_q[i] <= dlt_q[(i + 1) % MAX_TASKS];
						end
					end
				end
			end else if (cmd.ins_do) begin
				if (CW'(i) == pos_q) begin
					ids_q[i] <= id_q;
					dlt_q[i] <= d_q;
					per_q[i] <= nper_q;
				end else if (CW'(i) > pos_q && CW'(i) <= cnt_q) begin
					ids_q[i] <= ids_q[(i + MAX_TASKS - 1) % MAX_TASKS];
					per_q[i] <= per_q[(i + MAX_TASKS - 1) % MAX_TASKS];
					if (CW'(i) == pos_q + 1'b1)
						dlt_q[i] <= dlt_q[(i + MAX_TASKS - 1) % MAX_TASKS] - d_q;
					else
						dlt_q[i] <= dlt_q[(i + MAX_TASKS - 1) % MAX_TASKS];
				end
			end
		end
	end
endmodule

/* rtl/dqts_ctrl.sv */
// Controller FSM: sequences tick, add and delete over the datapath.
// Depends on dqts_pkg and the assertion macro header.
`include "delta_queue_task_scheduler_defines.svh"
module dqts_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       op,
	input  dqts_pkg::stat_t  stat,
	output dqts_pkg::cmd_t   cmd,
	input  logic [7:0]       cur_id,
	output logic             out_valid,
	input  logic             out_ready,
	output dqts_pkg::out_t   out_data
);
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_TICK  = 7'b0000010,
		S_INS   = 7'b0000100,
		S_DEL   = 7'b0001000,
		S_WAIT  = 7'b0010000,
		S_FIRE  = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic [4:0] nfire_q;
	logic       is_tick_q;
	logic       ov_q;
	dqts_pkg::out_t od_q;
	logic       emit;
	dqts_pkg::out_t emit_d;
	logic       slot_free;

	// fires are held one deep so the last one can be tagged
	logic       pend_q;
	logic [7:0] pid_q;
	logic       push_pend;

	assign slot_free = !ov_q || out_ready;
	assign out_valid = ov_q;
	assign out_data  = od_q;
	assign in_ready  = state_q == S_IDLE;
	assign push_pend = cmd.fire_pop;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		emit    = 1'b0;
		emit_d  = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					case (op)
						dqts_pkg::OP_TICK: if (!stat.empty) begin
							cmd.tick_dec = 1'b1;
							state_d = S_TICK;
						end
						dqts_pkg::OP_ADD: begin
							cmd.ins_start = 1'b1;
							state_d = S_INS;
						end
						dqts_pkg::OP_DEL: begin
							cmd.del_start = 1'b1;
							state_d = S_DEL;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_INS: begin
				// an add from the item checks for a full table; a reinsert of a fired task does not
				if (is_tick_q) begin
					if (stat.ins_here) begin
						cmd.ins_do = 1'b1;
						state_d = S_TICK;
					end else begin
						cmd.ins_step = 1'b1;
					end
				end else if (slot_free) begin
					if (stat.full) begin
						emit = 1'b1;
						emit_d = '{result_id: cur_id, status: dqts_pkg::ST_FULL, last: 1'b1};
						state_d = S_IDLE;
					end else if (stat.ins_here) begin
						cmd.ins_do = 1'b1;
						emit = 1'b1;
						emit_d = '{result_id: cur_id, status: dqts_pkg::ST_ADDED, last: 1'b1};
						state_d = S_IDLE;
					end else begin
						cmd.ins_step = 1'b1;
					end
				end
			end
			S_DEL: begin
				if (slot_free) begin
					if (stat.del_hit) begin
						cmd.del_do = 1'b1;
						emit = 1'b1;
						emit_d = '{result_id: cur_id, status: dqts_pkg::ST_REMOVED,
							last: 1'b1};
						state_d = S_IDLE;
					end else if (stat.del_end) begin
						emit = 1'b1;
						emit_d = '{result_id: cur_id, status: dqts_pkg::ST_NOTFND,
							last: 1'b1};
						state_d = S_IDLE;
					end else begin
						cmd.del_step = 1'b1;
					end
				end
			end
			S_TICK: begin
				if (stat.empty || !stat.head_zero || nfire_q == 5'(dqts_pkg::FIRE_LIMIT)) begin
					state_d = S_DONE;
				end else if (!pend_q || slot_free) begin
					// hold the pop while the pending fire cannot move
					cmd.fire_pop = 1'b1;
					state_d = S_FIRE;
				end
			end
			S_FIRE: begin
				if (stat.fire_per) begin
					cmd.ins_start = 1'b1;
					cmd.ins_src   = 1'b1;
					state_d = S_INS;
				end else begin
					state_d = S_TICK;
				end
			end
			S_WAIT: state_d = S_IDLE;
			S_DONE: begin
				// mark the final fire of this tick as last
				if (slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			nfire_q   <= '0;
			is_tick_q <= 1'b0;
			ov_q      <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE) begin
				nfire_q   <= '0;
				is_tick_q <= op == dqts_pkg::OP_TICK;
			end else if (push_pend && !(pend_q && !slot_free)) begin
				nfire_q <= nfire_q + 1'b1;
			end
			if (emit || (push_pend && pend_q && slot_free)
				|| (state_q == S_DONE && pend_q && slot_free)) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			if (push_pend && !(pend_q && !slot_free)) begin
				pend_q <= 1'b1;
			end else if (state_q == S_DONE && slot_free) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			od_q <= emit_d;
		end else if (push_pend && pend_q && slot_free) begin
			od_q <= '{result_id: pid_q, status: dqts_pkg::ST_FIRED, last: 1'b0};
		end else if (state_q == S_DONE && pend_q && slot_free) begin
			od_q <= '{result_id: pid_q, status: dqts_pkg::ST_FIRED, last: 1'b1};
		end
		if (push_pend && !(pend_q && !slot_free)) begin
			pid_q <= cur_id;
		end
	end

	`DQ_ASSERT_IMP(a_ready_idle, in_ready, state_q == S_IDLE, "ready outside idle")
	`DQ_ASSERT_IMP(a_one_cmd, 1'b1, $countones({cmd.ins_do, cmd.del_do, cmd.fire_pop}) <= 1,
		"conflicting table commands")
	`DQ_ASSERT_IMP(a_fire_cap, 1'b1, nfire_q <= 5'(dqts_pkg::FIRE_LIMIT), "fire count overrun")
	`DQ_ASSERT_NXT(a_onehot, 1'b1, $onehot(state_q), "state not one-hot")
endmodule

/* rtl/delta_queue_task_scheduler.sv */
// Top level of the delta-list task scheduler.
// Depends on dqts_pkg, dqts_if, dqts_ctrl and dqts_dp.
//
//  channel | dir | payload
//  in_ch   | in  | op, task_id, delay, period
//  out_ch  | out | result_id, status, last
//
// Add/delete walk the list one entry per cycle while the output is not stalled.
// A tick pops each due task in turn and walks each periodic one back into
// the list; fires are limited to 16 per tick.
// Reset clears the task count and the controller; the table has no reset.
// A stalled output holds adds, deletes, pops past a pending fire and the end of a tick; input is taken only idle.
module delta_queue_task_scheduler #(
	parameter int MAX_TASKS = 16
) (
	input logic clk,
	input logic arst_n,
	dqts_if.sink   in_ch,
	dqts_if.source out_ch
);
	dqts_pkg::cmd_t  cmd;
	dqts_pkg::stat_t stat;
	logic [7:0]      cur_id;
	dqts_pkg::in_t   item;

	assign item = '{op: in_ch.data.op, task_id: in_ch.data.task_id,
		delay: in_ch.data.delay, period: in_ch.data.period};

	dqts_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
		.clk(clk), .arst_n(arst_n), .item(item), .cmd(cmd), .stat(stat), .cur_id(cur_id)
	);

	dqts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.op(in_ch.data.op),
		.stat(stat), .cmd(cmd), .cur_id(cur_id),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
	);
endmodule
